// ----- rtl/subset_rank_unrank_macros.svh -----
// Assertion macros for the subset rank/unrank checker.
// Needs a clk and rst in scope where used.
`ifndef SUBSET_RANK_UNRANK_MACROS_SVH
`define SUBSET_RANK_UNRANK_MACROS_SVH
// same-cycle implication
`define SRR_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("srr assertion failed");
// next-cycle implication
`define SRR_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("srr assertion failed");
`endif

// ----- rtl/srr_pkg.sv -----
// Shared constants and controller/datapath command and status types
// for the subset rank/unrank block. No dependencies.
package srr_pkg;

  localparam int MAX_SET_SIZE = 63;
  localparam int DATA_W       = 64;
  localparam int SIZE_W       = 6;
  localparam int COL_W        = 7;   // column index 0..MAX_SET_SIZE+1
  localparam int ADDR_W       = SIZE_W + COL_W;
  localparam int OP_W         = 4;

  localparam logic [OP_W-1:0] CMD_NONE   = 4'd0;
  localparam logic [OP_W-1:0] CMD_BREAD  = 4'd1;
  localparam logic [OP_W-1:0] CMD_BWRITE = 4'd2;
  localparam logic [OP_W-1:0] CMD_LOAD   = 4'd3;
  localparam logic [OP_W-1:0] CMD_RREAD  = 4'd4;
  localparam logic [OP_W-1:0] CMD_RSTEP  = 4'd5;
  localparam logic [OP_W-1:0] CMD_SREAD  = 4'd6;
  localparam logic [OP_W-1:0] CMD_SDEC   = 4'd7;
  localparam logic [OP_W-1:0] CMD_UREAD  = 4'd8;
  localparam logic [OP_W-1:0] CMD_USTEP  = 4'd9;
  localparam logic [OP_W-1:0] CMD_FIN    = 4'd10;

  typedef struct packed {
    logic [OP_W-1:0] op;
  } srr_cmd_t;

  typedef struct packed {
    logic build_last;
    logic is_unrank;
    logic err;
    logic i_eq_n;
    logic i_zero;
    logic c_zero;
    logic gt;
    logic out_free;
  } srr_stat_t;

endpackage

// ----- rtl/srr_ctrl.sv -----
// Sequencer for the table build and the rank/unrank loops.
// Depends on srr_pkg; drives commands into srr_dp.
module srr_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  srr_pkg::srr_stat_t stat,
  output srr_pkg::srr_cmd_t  cmd
);
  import srr_pkg::*;

  localparam logic [3:0] ST_BREAD  = 4'd0;
  localparam logic [3:0] ST_BWRITE = 4'd1;
  localparam logic [3:0] ST_IDLE   = 4'd2;
  localparam logic [3:0] ST_DISP   = 4'd3;
  localparam logic [3:0] ST_RREAD  = 4'd4;
  localparam logic [3:0] ST_RSTEP  = 4'd5;
  localparam logic [3:0] ST_SREAD  = 4'd6;
  localparam logic [3:0] ST_SSTEP  = 4'd7;
  localparam logic [3:0] ST_UREAD  = 4'd8;
  localparam logic [3:0] ST_USTEP  = 4'd9;
  localparam logic [3:0] ST_DONE   = 4'd10;

  logic [3:0] state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_BREAD;
    end else begin
      state <= state_next;
    end
  end

  assign in_stall = (state != ST_IDLE);

  always_comb begin
    state_next = state;
    cmd.op     = CMD_NONE;
    case (state)
      ST_BREAD: begin
        cmd.op     = CMD_BREAD;
        state_next = ST_BWRITE;
      end
      ST_BWRITE: begin
        cmd.op     = CMD_BWRITE;
        state_next = stat.build_last ? ST_IDLE : ST_BREAD;
      end
      ST_IDLE: begin
        if (in_valid) begin
          cmd.op     = CMD_LOAD;
          state_next = ST_DISP;
        end
      end
      ST_DISP: begin
        if (!stat.is_unrank) state_next = ST_RREAD;
        else if (stat.err)   state_next = ST_DONE;
        else                 state_next = ST_SREAD;
      end
      ST_RREAD: begin
        if (stat.i_eq_n) begin
          state_next = ST_DONE;
        end else begin
          cmd.op     = CMD_RREAD;
          state_next = ST_RSTEP;
        end
      end
      ST_RSTEP: begin
        cmd.op     = CMD_RSTEP;
        state_next = ST_RREAD;
      end
      ST_SREAD: begin
        if (stat.c_zero) begin
          state_next = ST_UREAD;
        end else begin
          cmd.op     = CMD_SREAD;
          state_next = ST_SSTEP;
        end
      end
      ST_SSTEP: begin
        if (stat.gt) begin
          cmd.op     = CMD_SDEC;
          state_next = ST_SREAD;
        end else begin
          state_next = ST_UREAD;
        end
      end
      ST_UREAD: begin
        if (stat.i_zero) begin
          state_next = ST_DONE;
        end else begin
          cmd.op     = CMD_UREAD;
          state_next = ST_USTEP;
        end
      end
      ST_USTEP: begin
        cmd.op     = CMD_USTEP;
        state_next = ST_UREAD;
      end
      ST_DONE: begin
        if (stat.out_free) begin
          cmd.op     = CMD_FIN;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_BREAD;
    endcase
  end

endmodule

// ----- rtl/srr_dp.sv -----
// Datapath: cumulative binomial table memory, item registers, output register.
// Depends on srr_pkg; executes commands from srr_ctrl.
module srr_dp (
  input  logic                        clk,
  input  logic                        rst,
  input  srr_pkg::srr_cmd_t           cmd,
  output srr_pkg::srr_stat_t          stat,
  input  logic                        cfg_valid,
  input  logic [srr_pkg::SIZE_W-1:0]  cfg_data,
  input  logic                        kind,
  input  logic [srr_pkg::DATA_W-1:0]  subset_bits,
  input  logic [srr_pkg::DATA_W-1:0]  rank_value,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [srr_pkg::DATA_W-1:0]  result_value,
  output logic                        range_error
);
  import srr_pkg::*;

  localparam logic [COL_W-1:0] LAST_COL = COL_W'(MAX_SET_SIZE + 1);
  localparam logic [SIZE_W-1:0] LAST_ROW = SIZE_W'(MAX_SET_SIZE);

  // tab[{r,c}] = sum of C(r,k) over k < c
  logic [DATA_W-1:0] tab [0:(1<<ADDR_W)-1];
  logic [DATA_W-1:0] rd_data, prev;
  logic [ADDR_W-1:0] rd_addr;
  logic              rd_en;

  logic [SIZE_W-1:0] set_size, n, i;
  logic [COL_W-1:0]  c, c_step;
  logic [DATA_W-1:0] x, w, acc, y, wval;
  logic              unrank, err;

  always_ff @(posedge clk) begin
    if (rst) begin
      set_size <= SIZE_W'(8);
    end else if (cfg_valid) begin
      set_size <= cfg_data;
    end
  end

  assign n = (set_size > LAST_ROW) ? LAST_ROW : set_size;

  // read address per command
  assign c_step = c + {{(COL_W-1){1'b0}}, w[i]};
  always_comb begin
    rd_en   = 1'b1;
    rd_addr = {i - SIZE_W'(1), c};
    case (cmd.op)
      CMD_BREAD: rd_addr = {i - SIZE_W'(1), c};
      CMD_RREAD: rd_addr = {i, c_step};
      CMD_SREAD: rd_addr = {n, c};
      CMD_UREAD: rd_addr = {i - SIZE_W'(1), c};
      default:   rd_en   = 1'b0;
    endcase
  end

  // row 0 is constant, later rows add two neighbors of the row above
  assign wval = (i == '0) ? ((c == '0) ? '0 : DATA_W'(1))
                          : (rd_data + ((c == '0) ? '0 : prev));

  always_ff @(posedge clk) begin
    if (rd_en) rd_data <= tab[rd_addr];
    if (cmd.op == CMD_BWRITE) tab[{i, c}] <= wval;
  end

  assign y = x - rd_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      i <= '0;
      c <= '0;
    end else begin
      case (cmd.op)
        CMD_BWRITE: begin
          prev <= rd_data;
          if (c == LAST_COL) begin
            c <= '0;
            i <= i + SIZE_W'(1);
          end else begin
            c <= c + COL_W'(1);
          end
        end
        CMD_LOAD: begin
          unrank <= kind;
          x      <= rank_value;
          err    <= kind && ((rank_value >> n) != '0);
          w      <= kind ? '0 : (subset_bits & ~({DATA_W{1'b1}} << n));
          acc    <= '0;
          i      <= kind ? n : '0;
          c      <= kind ? {1'b0, n} : '0;
        end
        CMD_RREAD: c <= c_step;
        CMD_RSTEP: begin
          acc <= acc + rd_data;
          i   <= i + SIZE_W'(1);
        end
        CMD_SDEC: c <= c - COL_W'(1);
        CMD_USTEP: begin
          if ((c != '0) && (y < rd_data)) begin
            w[i - SIZE_W'(1)] <= 1'b1;
            c <= c - COL_W'(1);
          end
          x <= y;
          i <= i - SIZE_W'(1);
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.op == CMD_FIN) begin
      out_valid    <= 1'b1;
      result_value <= !unrank ? acc : (err ? '0 : w);
      range_error  <= err;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_comb begin
    stat.build_last = (i == LAST_ROW) && (c == LAST_COL);
    stat.is_unrank  = unrank;
    stat.err        = err;
    stat.i_eq_n     = (i == n);
    stat.i_zero     = (i == '0);
    stat.c_zero     = (c == '0);
    stat.gt         = (rd_data > x);
    stat.out_free   = !out_valid || !out_stall;
  end

endmodule

// ----- rtl/subset_rank_unrank.sv -----
// Subset rank/unrank. After reset the binomial table is built while the input is stalled.
// Rank reads the table once per element, n = set size, then writes the output register.
// Unrank first searches the table for c0, the cardinality, then walks the n elements.
// An out-of-range index skips both and gives range_error with a zero result.
// One item in flight; the next request is taken while the result waits to be taken.
// rst is synchronous, active high; set_size resets to 8.
module subset_rank_unrank (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [srr_pkg::SIZE_W-1:0]  cfg_data,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        kind,
  input  logic [srr_pkg::DATA_W-1:0]  subset_bits,
  input  logic [srr_pkg::DATA_W-1:0]  rank_value,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [srr_pkg::DATA_W-1:0]  result_value,
  output logic                        range_error
);
  import srr_pkg::*;

  srr_cmd_t  cmd;
  srr_stat_t stat;

  assign cfg_ready = 1'b1;

  srr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  srr_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .cfg_valid    (cfg_valid && cfg_ready),
    .cfg_data     (cfg_data),
    .kind         (kind),
    .subset_bits  (subset_bits),
    .rank_value   (rank_value),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .result_value (result_value),
    .range_error  (range_error)
  );

endmodule

// ----- rtl/srr_checker.sv -----
// Port-level checks for subset_rank_unrank, attached by bind.
// Depends on srr_pkg and subset_rank_unrank_macros.svh.
`include "subset_rank_unrank_macros.svh"
module srr_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       in_valid,
  input logic                       in_stall,
  input logic                       out_valid,
  input logic                       out_stall,
  input logic [srr_pkg::DATA_W-1:0] result_value,
  input logic                       range_error
);
  `SRR_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid)
  `SRR_ASSERT_NXT(a_out_stable, out_valid && out_stall, $stable(result_value))
  `SRR_ASSERT_IMP(a_err_zero, out_valid && range_error, result_value == '0)
  `SRR_ASSERT_NXT(a_busy_after_req, in_valid && !in_stall, in_stall)
endmodule

bind subset_rank_unrank srr_checker u_srr_checker (.*);
